@@ rtl/cbor_tok_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package cbor_tok_pkg;

    localparam int MAX_NEST_DEF = 16;

    // token kinds
    localparam logic [3:0] TK_UINT     = 4'd0;
    localparam logic [3:0] TK_NEGINT   = 4'd1;
    localparam logic [3:0] TK_BYTES    = 4'd2;
    localparam logic [3:0] TK_TEXT     = 4'd3;
    localparam logic [3:0] TK_ARRAY    = 4'd4;
    localparam logic [3:0] TK_MAP      = 4'd5;
    localparam logic [3:0] TK_FALSE    = 4'd6;
    localparam logic [3:0] TK_TRUE     = 4'd7;
    localparam logic [3:0] TK_NULL     = 4'd8;
    localparam logic [3:0] TK_F32      = 4'd9;
    localparam logic [3:0] TK_F64      = 4'd10;
    localparam logic [3:0] TK_PAYLOAD  = 4'd11;
    localparam logic [3:0] TK_STR_END  = 4'd12;
    localparam logic [3:0] TK_CONT_END = 4'd13;
    localparam logic [3:0] TK_ERROR    = 4'd14;

    // error codes
    localparam logic [3:0] ERR_NONE      = 4'd0;
    localparam logic [3:0] ERR_TRUNC     = 4'd1;
    localparam logic [3:0] ERR_BAD_INFO  = 4'd2;
    localparam logic [3:0] ERR_BAD_M7    = 4'd3;
    localparam logic [3:0] ERR_SIMPLE    = 4'd4;
    localparam logic [3:0] ERR_HALF      = 4'd5;
    localparam logic [3:0] ERR_CHUNK     = 4'd6;
    localparam logic [3:0] ERR_KEY       = 4'd7;
    localparam logic [3:0] ERR_DEEP      = 4'd8;

    // major types
    localparam logic [2:0] MT_UINT   = 3'd0;
    localparam logic [2:0] MT_NEGINT = 3'd1;
    localparam logic [2:0] MT_BYTES  = 3'd2;
    localparam logic [2:0] MT_TEXT   = 3'd3;
    localparam logic [2:0] MT_ARRAY  = 3'd4;
    localparam logic [2:0] MT_MAP    = 3'd5;
    localparam logic [2:0] MT_TAG    = 3'd6;
    localparam logic [2:0] MT_SIMPLE = 3'd7;

    // additional info codes
    localparam logic [4:0] AI_FALSE = 5'd20;
    localparam logic [4:0] AI_TRUE  = 5'd21;
    localparam logic [4:0] AI_NULL  = 5'd22;
    localparam logic [4:0] AI_UNDEF = 5'd23;
    localparam logic [4:0] AI_ONE   = 5'd24;
    localparam logic [4:0] AI_TWO   = 5'd25;
    localparam logic [4:0] AI_FOUR  = 5'd26;
    localparam logic [4:0] AI_EIGHT = 5'd27;
    localparam logic [4:0] AI_INDEF = 5'd31;

    localparam logic [7:0] BREAK_BYTE = 8'hff;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_buffer;
    } in_t;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [63:0] argument;
        logic        is_indefinite;
        logic [4:0]  nest_level;
        logic [4:0]  levels_closed;
        logic        value_done;
        logic [3:0]  error_code;
    } out_t;

endpackage
`default_nettype wire

@@ rtl/cbor_stream_tokenizer_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// The token of an accepted input beat is written to the output register as the beat is accepted.
// Throughput: one byte per cycle unless the output is stalled; the nesting close chain
// is a priority scan over per-level close flags, settled in the same cycle as the byte.
// Reset: aresetn low synchronously clears parser state, stack pointer and the
// output valid; stack entries are written on each push and need no clearing.
module cbor_stream_tokenizer_core #(
    parameter int MAX_NEST = cbor_tok_pkg::MAX_NEST_DEF
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  wire cbor_tok_pkg::in_t s_data,
    output logic                m_valid,
    input  wire                 m_ready,
    output cbor_tok_pkg::out_t  m_data
);
    import cbor_tok_pkg::*;

    localparam int SPW = $clog2(MAX_NEST + 1);
    localparam int IW  = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;

    // parser state
    logic [7:0]     head_reg, head_next;
    logic [3:0]     argleft_reg, argleft_next;
    logic [63:0]    acc_reg, acc_next;
    logic [63:0]    pay_reg, pay_next;
    logic [1:0]     chunk_reg, chunk_next;
    logic [SPW-1:0] sp_reg, sp_next;
    logic           errhold_reg, errhold_next;
    logic           tag_reg, tag_next;

    // stack entries: remaining count and flags {val, map, ind}
    logic [63:0]    rem_reg [MAX_NEST];
    logic [2:0]     fl_reg  [MAX_NEST];

    logic           m_valid_reg;
    out_t           m_data_reg;

    // combinational results
    logic           emit;
    out_t           tok;
    logic           do_push;
    logic [63:0]    push_rem;
    logic [2:0]     push_fl;
    logic           do_cmp;
    logic [MAX_NEST-1:0] target;
    logic           accepted;

    assign accepted = s_valid && s_ready;
    assign s_ready  = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_comb begin
        logic [7:0]     b;
        logic [2:0]     mj;
        logic [4:0]     inf;
        logic [2:0]     top_f;
        logic           disp_go;
        logic [7:0]     dh;
        logic [63:0]    da;
        logic [2:0]     dmj;
        logic [4:0]     dinf;
        logic           pop1;
        logic           do_reset;
        logic           busy;
        logic [SPW-1:0] sp_base;
        logic           carry;
        logic [MAX_NEST-1:0] popped;
        logic           pass;

        b       = s_data.in_byte;
        mj      = b[7:5];
        inf     = b[4:0];
        top_f   = (sp_reg != '0) ? fl_reg[IW'(sp_reg - SPW'(1))] : 3'b000;
        disp_go = 1'b0;
        dh      = b;
        da      = 64'(inf);
        dmj     = '0;
        dinf    = '0;
        busy    = 1'b0;
        pop1    = 1'b0;
        do_reset = 1'b0;
        emit    = 1'b0;
        tok     = '0;
        do_push = 1'b0;
        push_rem = '0;
        push_fl  = '0;
        do_cmp  = 1'b0;

        head_next    = head_reg;
        argleft_next = argleft_reg;
        acc_next     = acc_reg;
        pay_next     = pay_reg;
        chunk_next   = chunk_reg;
        errhold_next = errhold_reg;
        tag_next     = tag_reg;
        sp_next      = sp_reg;
        tok.nest_level = 5'(sp_reg);

        if (errhold_reg) begin
            // drop bytes until the buffer ends
            do_reset = s_data.end_of_buffer;
        end else begin
            if (pay_reg != '0) begin
                // string payload byte
                pay_next       = pay_reg - 64'd1;
                emit           = 1'b1;
                tok.token_kind = TK_PAYLOAD;
                tok.argument   = 64'(b);
                do_cmp         = (pay_reg == 64'd1) && (chunk_reg == 2'd0);
            end else if (argleft_reg != '0) begin
                // collect argument bytes, big endian
                acc_next     = {acc_reg[55:0], b};
                argleft_next = argleft_reg - 4'd1;
                if (argleft_reg == 4'd1) begin
                    disp_go = 1'b1;
                    dh      = head_reg;
                    da      = {acc_reg[55:0], b};
                end
            end else if (chunk_reg != 2'd0) begin
                // inside an indefinite string
                if (b == BREAK_BYTE) begin
                    chunk_next     = 2'd0;
                    emit           = 1'b1;
                    tok.token_kind = TK_STR_END;
                    do_cmp         = 1'b1;
                end else if (mj != {1'b0, chunk_reg} + 3'd1) begin
                    emit = 1'b1; tok.token_kind = TK_ERROR; tok.error_code = ERR_CHUNK;
                end else if (inf > AI_EIGHT) begin
                    emit = 1'b1; tok.token_kind = TK_ERROR; tok.error_code = ERR_BAD_INFO;
                end else if (inf < AI_ONE) begin
                    disp_go = 1'b1;
                end else begin
                    head_next    = b;
                    argleft_next = 4'd1 << (inf - AI_ONE);
                    acc_next     = '0;
                end
            end else begin
                if (b == BREAK_BYTE) begin
                    if (!tag_reg && sp_reg != '0 && top_f[0] && !(top_f[1] && top_f[2])) begin
                        pop1           = 1'b1;
                        emit           = 1'b1;
                        tok.token_kind = TK_CONT_END;
                        tok.nest_level = 5'(sp_reg - SPW'(1));
                        do_cmp         = 1'b1;
                    end else begin
                        emit = 1'b1; tok.token_kind = TK_ERROR; tok.error_code = ERR_BAD_M7;
                    end
                end else if (inf > AI_EIGHT && !(inf == AI_INDEF && mj >= MT_BYTES
                                                  && mj <= MT_MAP)) begin
                    emit = 1'b1; tok.token_kind = TK_ERROR;
                    tok.error_code = (mj == MT_SIMPLE) ? ERR_BAD_M7 : ERR_BAD_INFO;
                end else if (sp_reg != '0 && top_f[1] && !top_f[2] && mj != MT_TEXT
                             && mj != MT_TAG) begin
                    emit = 1'b1; tok.token_kind = TK_ERROR; tok.error_code = ERR_KEY;
                end else if (inf < AI_ONE || inf == AI_INDEF) begin
                    disp_go = 1'b1;
                end else begin
                    head_next    = b;
                    argleft_next = 4'd1 << (inf - AI_ONE);
                    acc_next     = '0;
                end
            end

            // act on a complete head and argument
            dmj  = dh[7:5];
            dinf = dh[4:0];
            if (disp_go) begin
                tok.argument = da;
                if (chunk_reg != 2'd0) begin
                    pay_next = da;
                end else begin
                    if (dmj != MT_TAG) tag_next = 1'b0;
                    case (dmj)
                        MT_UINT, MT_NEGINT: begin
                            emit = 1'b1; tok.token_kind = {1'b0, dmj}; do_cmp = 1'b1;
                        end
                        MT_BYTES, MT_TEXT: begin
                            emit = 1'b1; tok.token_kind = {1'b0, dmj};
                            if (dinf == AI_INDEF) begin
                                tok.is_indefinite = 1'b1;
                                tok.argument      = '0;
                                chunk_next        = dmj[1:0] - 2'd1;
                            end else if (da == '0) begin
                                do_cmp = 1'b1;
                            end else begin
                                pay_next = da;
                            end
                        end
                        MT_ARRAY, MT_MAP: begin
                            if (dinf == AI_INDEF || da != '0) begin
                                if (32'(sp_reg) >= MAX_NEST) begin
                                    emit = 1'b1; tok.token_kind = TK_ERROR;
                                    tok.error_code = ERR_DEEP;
                                end else begin
                                    do_push  = 1'b1;
                                    push_rem = (dinf == AI_INDEF) ? '0 : da;
                                    push_fl  = {1'b0, dmj == MT_MAP, dinf == AI_INDEF};
                                    sp_next  = sp_reg + SPW'(1);
                                    emit = 1'b1; tok.token_kind = {1'b0, dmj};
                                    if (dinf == AI_INDEF) begin
                                        tok.is_indefinite = 1'b1;
                                        tok.argument      = '0;
                                    end
                                end
                            end else begin
                                emit = 1'b1; tok.token_kind = {1'b0, dmj}; do_cmp = 1'b1;
                            end
                        end
                        MT_TAG: begin
                            tag_next = 1'b1;
                        end
                        default: begin
                            emit = 1'b1;
                            if (dinf < AI_FALSE || dinf == AI_ONE) begin
                                tok.token_kind = TK_ERROR; tok.error_code = ERR_SIMPLE;
                            end else if (dinf == AI_TWO) begin
                                tok.token_kind = TK_ERROR; tok.error_code = ERR_HALF;
                            end else if (dinf == AI_FOUR || dinf == AI_EIGHT) begin
                                tok.token_kind = (dinf == AI_FOUR) ? TK_F32 : TK_F64;
                                do_cmp = 1'b1;
                            end else begin
                                tok.token_kind = (dinf == AI_FALSE) ? TK_FALSE :
                                                 (dinf == AI_TRUE)  ? TK_TRUE  : TK_NULL;
                                tok.argument   = '0;
                                do_cmp = 1'b1;
                            end
                        end
                    endcase
                end
            end
            if (tok.token_kind == TK_ERROR && emit) begin
                tok.argument      = '0;
                tok.is_indefinite = 1'b0;
            end
        end

        // priority scan: levels that close as the item completes
        sp_base = pop1 ? sp_reg - SPW'(1) : sp_reg;
        carry   = 1'b1;
        popped  = '0;
        target  = '0;
        for (int i = MAX_NEST - 1; i >= 0; i--) begin
            pass = !fl_reg[i][0] && (!fl_reg[i][1] || fl_reg[i][2]) && (rem_reg[i] == 64'd1);
            if (32'(sp_base) > i) begin
                if (carry) begin
                    if (pass) popped[i] = 1'b1;
                    else      target[i] = 1'b1;
                end
                carry = carry && pass;
            end
        end
        if (!do_cmp) target = '0;
        if (pop1) sp_next = sp_base;
        if (do_cmp) begin
            tok.levels_closed = 5'($countones(popped));
            tok.value_done    = carry;
            sp_next           = sp_base - SPW'($countones(popped));
        end

        if (!errhold_reg) begin
            if (emit && tok.token_kind == TK_ERROR) begin
                tok.nest_level    = 5'(sp_reg);
                tok.levels_closed = '0;
                tok.value_done    = 1'b0;
                if (s_data.end_of_buffer) do_reset = 1'b1;
                else                      errhold_next = 1'b1;
                do_push = 1'b0;
                target  = '0;
            end else if (s_data.end_of_buffer) begin
                busy = (sp_next != '0) || (argleft_next != '0) || (pay_next != '0)
                       || (chunk_next != 2'd0) || tag_next;
                if (busy) begin
                    tok            = '0;
                    tok.token_kind = TK_ERROR;
                    tok.error_code = ERR_TRUNC;
                    tok.nest_level = 5'(sp_next);
                    emit           = 1'b1;
                    do_reset       = 1'b1;
                    do_push        = 1'b0;
                    target         = '0;
                end
            end
        end

        // return to the idle state
        if (do_reset) begin
            head_next    = '0;
            argleft_next = '0;
            acc_next     = '0;
            pay_next     = '0;
            chunk_next   = '0;
            sp_next      = '0;
            errhold_next = 1'b0;
            tag_next     = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            argleft_reg <= '0;
            acc_reg     <= '0;
            pay_reg     <= '0;
            chunk_reg   <= '0;
            sp_reg      <= '0;
            errhold_reg <= 1'b0;
            tag_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accepted) begin
                head_reg    <= head_next;
                argleft_reg <= argleft_next;
                acc_reg     <= acc_next;
                pay_reg     <= pay_next;
                chunk_reg   <= chunk_next;
                sp_reg      <= sp_next;
                errhold_reg <= errhold_next;
                tag_reg     <= tag_next;
                m_valid_reg <= emit;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (accepted && emit) begin
            m_data_reg <= tok;
        end
    end

    // stack cells: push at the top, advance the level that absorbs the item
    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_NEST; i++) begin
            if (accepted) begin
                if (do_push && 32'(sp_reg) == i) begin
                    rem_reg[i] <= push_rem;
                    fl_reg[i]  <= push_fl;
                end else if (target[i]) begin
                    if (fl_reg[i][1] && !fl_reg[i][2]) begin
                        fl_reg[i][2] <= 1'b1;
                    end else begin
                        fl_reg[i][2] <= 1'b0;
                        if (!fl_reg[i][0]) rem_reg[i] <= rem_reg[i] - 64'd1;
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 1ps
module tb;
    import cbor_tok_pkg::*;

    localparam int NEST_LIMIT = MAX_NEST_DEF;
    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_AT_BEAT = 300;
    localparam int HOLD_CYCLES = 300;
    localparam logic [2:0] FL_IND = 3'b001;
    localparam logic [2:0] FL_MAP = 3'b010;
    localparam logic [2:0] FL_VAL = 3'b100;

    typedef struct {
        in_t beat;
        bit  drain_first;
    } pending_beat_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    cbor_stream_tokenizer_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    pending_beat_t beats_q[$];
    out_t tokens_due[$];
    logic [7:0] enc_q[$];

    int n_sent = 0;
    int n_tokens = 0;
    int n_err_tokens = 0;
    int n_mismatch = 0;
    int n_buffers = 0;
    int cycles = 0;
    int gap_left = 0;
    int stall_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    // decoder shadow state
    logic [7:0]  p_head;
    int          p_argleft;
    logic [63:0] p_acc;
    logic [63:0] p_payleft;
    int          p_chunk;
    int          p_sp;
    logic [63:0] p_rem[NEST_LIMIT];
    logic [2:0]  p_flg[NEST_LIMIT];
    bit          p_err;
    bit          p_tag;

    // token under construction
    logic [3:0]  t_kind;
    logic [63:0] t_arg;
    bit          t_ind;
    int          t_lvl;
    int          t_closed;
    bit          t_done;
    logic [3:0]  t_err;

    function automatic void clear_decoder();
        p_head = '0;
        p_argleft = 0;
        p_acc = '0;
        p_payleft = '0;
        p_chunk = 0;
        p_sp = 0;
        p_err = 1'b0;
        p_tag = 1'b0;
    endfunction

    function automatic void clear_token();
        t_kind = '0;
        t_arg = '0;
        t_ind = 1'b0;
        t_lvl = 0;
        t_closed = 0;
        t_done = 1'b0;
        t_err = ERR_NONE;
    endfunction

    function automatic bit fail(logic [3:0] code);
        t_kind = TK_ERROR;
        t_arg = '0;
        t_ind = 1'b0;
        t_err = code;
        return 1'b1;
    endfunction

    // finish one item: advance enclosing levels, pop the ones that run out
    function automatic void finish_item();
        int i;
        logic [2:0] f;
        while (p_sp > 0) begin
            i = p_sp - 1;
            f = p_flg[i];
            if (f & FL_MAP) begin
                if (!(f & FL_VAL)) begin
                    p_flg[i] = f | FL_VAL;
                    return;
                end
                p_flg[i] = f & ~FL_VAL;
            end
            if (f & FL_IND) return;
            p_rem[i] = p_rem[i] - 1;
            if (p_rem[i] != 0) return;
            p_sp--;
            t_closed++;
        end
        t_done = 1'b1;
    endfunction

    function automatic bit run_head(logic [7:0] h, logic [63:0] a);
        logic [2:0] mj;
        logic [4:0] inf;
        mj = h[7:5];
        inf = h[4:0];
        t_arg = a;
        if (p_chunk != 0) begin
            p_payleft = a;
            return 1'b0;
        end
        if (mj != MT_TAG) p_tag = 1'b0;
        case (mj)
            MT_UINT, MT_NEGINT: begin
                t_kind = 4'(mj);
                finish_item();
                return 1'b1;
            end
            MT_BYTES, MT_TEXT: begin
                t_kind = 4'(mj);
                if (inf == AI_INDEF) begin
                    t_ind = 1'b1;
                    t_arg = '0;
                    p_chunk = int'(mj) - 1;
                end else if (a == 0) begin
                    finish_item();
                end else begin
                    p_payleft = a;
                end
                return 1'b1;
            end
            MT_ARRAY, MT_MAP: begin
                if (inf == AI_INDEF || a != 0) begin
                    if (p_sp >= NEST_LIMIT) return fail(ERR_DEEP);
                    p_rem[p_sp] = (inf == AI_INDEF) ? 64'd0 : a;
                    p_flg[p_sp] = ((inf == AI_INDEF) ? FL_IND : 3'b000)
                                | ((mj == MT_MAP) ? FL_MAP : 3'b000);
                    p_sp++;
                    t_kind = 4'(mj);
                    if (inf == AI_INDEF) begin
                        t_ind = 1'b1;
                        t_arg = '0;
                    end
                    return 1'b1;
                end
                t_kind = 4'(mj);
                finish_item();
                return 1'b1;
            end
            MT_TAG: begin
                p_tag = 1'b1;
                return 1'b0;
            end
            default: begin
                if (inf < AI_FALSE || inf == AI_ONE) return fail(ERR_SIMPLE);
                if (inf == AI_TWO) return fail(ERR_HALF);
                if (inf == AI_FOUR || inf == AI_EIGHT) begin
                    t_kind = (inf == AI_FOUR) ? TK_F32 : TK_F64;
                end else begin
                    t_kind = (inf == AI_FALSE) ? TK_FALSE :
                             (inf == AI_TRUE) ? TK_TRUE : TK_NULL;
                    t_arg = '0;
                end
                finish_item();
                return 1'b1;
            end
        endcase
    endfunction

    function automatic bit scan_byte(logic [7:0] b);
        logic [2:0] mj;
        logic [4:0] inf;
        logic [2:0] f;
        mj = b[7:5];
        inf = b[4:0];
        t_lvl = p_sp;
        if (p_payleft != 0) begin
            p_payleft = p_payleft - 1;
            t_kind = TK_PAYLOAD;
            t_arg = {56'd0, b};
            if (p_payleft == 0 && p_chunk == 0) finish_item();
            return 1'b1;
        end
        if (p_argleft != 0) begin
            p_acc = {p_acc[55:0], b};
            p_argleft--;
            if (p_argleft != 0) return 1'b0;
            return run_head(p_head, p_acc);
        end
        if (p_chunk != 0) begin
            if (b == BREAK_BYTE) begin
                p_chunk = 0;
                t_kind = TK_STR_END;
                finish_item();
                return 1'b1;
            end
            if (int'(mj) != p_chunk + 1) return fail(ERR_CHUNK);
            if (inf > AI_EIGHT) return fail(ERR_BAD_INFO);
        end else begin
            f = (p_sp > 0) ? p_flg[p_sp-1] : 3'b000;
            if (b == BREAK_BYTE) begin
                if (!p_tag && p_sp > 0 && (f & FL_IND)
                        && !((f & FL_MAP) && (f & FL_VAL))) begin
                    p_sp--;
                    t_kind = TK_CONT_END;
                    t_lvl = p_sp;
                    finish_item();
                    return 1'b1;
                end
                return fail(ERR_BAD_M7);
            end
            if (inf > AI_EIGHT && !(inf == AI_INDEF && mj >= MT_BYTES && mj <= MT_MAP))
                return fail((mj == MT_SIMPLE) ? ERR_BAD_M7 : ERR_BAD_INFO);
            if (p_sp > 0 && (f & FL_MAP) && !(f & FL_VAL) && mj != MT_TEXT && mj != MT_TAG)
                return fail(ERR_KEY);
        end
        if (inf < AI_ONE || inf == AI_INDEF) return run_head(b, {59'd0, inf});
        p_head = b;
        p_argleft = 1 << (inf - AI_ONE);
        p_acc = '0;
        return 1'b0;
    endfunction

    function automatic void queue_token();
        out_t e;
        e.token_kind = t_kind;
        e.argument = t_arg;
        e.is_indefinite = t_ind;
        e.nest_level = t_lvl[4:0];
        e.levels_closed = t_closed[4:0];
        e.value_done = t_done;
        e.error_code = t_err;
        tokens_due.push_back(e);
    endfunction

    // predict the token, if any, for one accepted byte
    function automatic void tokenize_byte(in_t x);
        bit got;
        if (p_err) begin
            if (x.end_of_buffer) clear_decoder();
            return;
        end
        clear_token();
        got = scan_byte(x.in_byte);
        if (got && t_kind == TK_ERROR) begin
            t_lvl = p_sp;
            t_closed = 0;
            t_done = 1'b0;
            queue_token();
            if (x.end_of_buffer) clear_decoder();
            else p_err = 1'b1;
            return;
        end
        if (x.end_of_buffer && (p_sp != 0 || p_argleft != 0 || p_payleft != 0
                || p_chunk != 0 || p_tag)) begin
            clear_token();
            t_lvl = p_sp;
            void'(fail(ERR_TRUNC));
            queue_token();
            clear_decoder();
            return;
        end
        if (got) queue_token();
    endfunction

    // encoding helpers
    function automatic logic [63:0] pick_arg();
        case ($urandom_range(0, 6))
            0: return 64'($urandom_range(0, 23));
            1: return 64'($urandom_range(0, 255));
            2: return 64'($urandom_range(0, 65535));
            3: return 64'($urandom);
            4: return {32'($urandom), 32'($urandom)};
            5: return '1;
            default: return '0;
        endcase
    endfunction

    function automatic void put_head(logic [2:0] mj, logic [63:0] v);
        int k;
        if (v < 24 && $urandom_range(0, 2) != 0) begin
            enc_q.push_back({mj, v[4:0]});
            return;
        end
        k = (v < 64'h100) ? 0 : (v < 64'h10000) ? 1 : (v < 64'h100000000) ? 2 : 3;
        if ($urandom_range(0, 4) == 0) k = $urandom_range(k, 3);
        enc_q.push_back({mj, 5'(AI_ONE + k)});
        for (int i = (1 << k) - 1; i >= 0; i--) enc_q.push_back(v[8*i +: 8]);
    endfunction

    function automatic void put_string(logic [2:0] mj);
        int n;
        if ($urandom_range(0, 3) == 0) begin
            enc_q.push_back({mj, AI_INDEF});
            repeat ($urandom_range(0, 2)) begin
                n = $urandom_range(0, 3);
                put_head(mj, 64'(n));
                repeat (n) enc_q.push_back(8'($urandom));
            end
            enc_q.push_back(BREAK_BYTE);
        end else begin
            n = $urandom_range(0, 4);
            put_head(mj, 64'(n));
            repeat (n) enc_q.push_back(8'($urandom));
        end
    endfunction

    function automatic void put_value(int depth);
        int n;
        int sel;
        sel = (depth > 3) ? $urandom_range(0, 4) : $urandom_range(0, 12);
        case (sel)
            0: put_head(MT_UINT, pick_arg());
            1: put_head(MT_NEGINT, pick_arg());
            2: put_string(MT_BYTES);
            3: put_string(MT_TEXT);
            4: enc_q.push_back({MT_SIMPLE, 5'($urandom_range(AI_FALSE, AI_UNDEF))});
            5: begin
                enc_q.push_back({MT_SIMPLE, ($urandom_range(0, 1) != 0) ? AI_FOUR : AI_EIGHT});
                repeat ((enc_q[$][0] == 1'b0) ? 4 : 8) enc_q.push_back(8'($urandom));
            end
            6: begin
                n = $urandom_range(0, 3);
                put_head(MT_ARRAY, 64'(n));
                repeat (n) put_value(depth + 1);
            end
            7: begin
                enc_q.push_back({MT_ARRAY, AI_INDEF});
                repeat ($urandom_range(0, 3)) put_value(depth + 1);
                enc_q.push_back(BREAK_BYTE);
            end
            8: begin
                n = $urandom_range(0, 2);
                put_head(MT_MAP, 64'(n));
                repeat (n) begin
                    put_string(MT_TEXT);
                    put_value(depth + 1);
                end
            end
            9: begin
                enc_q.push_back({MT_MAP, AI_INDEF});
                repeat ($urandom_range(0, 2)) begin
                    if ($urandom_range(0, 3) == 0) put_head(MT_TAG, pick_arg());
                    put_string(MT_TEXT);
                    put_value(depth + 1);
                end
                enc_q.push_back(BREAK_BYTE);
            end
            10: begin
                put_head(MT_TAG, pick_arg());
                put_value(depth);
            end
            11: begin
                // nesting chain around the stack limit
                n = $urandom_range(NEST_LIMIT - 2, NEST_LIMIT + 2);
                repeat (n) put_head(MT_ARRAY, 64'd1);
                put_value(depth + 5);
            end
            default: put_head(MT_UINT, 64'($urandom_range(0, 30)));
        endcase
    endfunction

    // move the encoded bytes into the beat queue, last one closes the buffer
    function automatic void flush_buffer(bit drain);
        pending_beat_t pb;
        foreach (enc_q[i]) begin
            pb.beat.in_byte = enc_q[i];
            pb.beat.end_of_buffer = (i == enc_q.size() - 1);
            pb.drain_first = drain && (i == 0);
            beats_q.push_back(pb);
        end
        enc_q.delete();
        n_buffers++;
    endfunction

    function automatic void push_bytes(input logic [7:0] b[$]);
        foreach (b[i]) enc_q.push_back(b[i]);
        flush_buffer(1'b0);
    endfunction

    // reset and stimulus
    initial begin
        int pos;
        int total;
        clear_decoder();
        // directed: extremes and special cases
        push_bytes('{8'h1b, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff});
        push_bytes('{BREAK_BYTE});
        push_bytes('{8'h1c});
        push_bytes('{8'ha1, 8'h01});
        push_bytes('{8'hf9, 8'h00, 8'h00});
        push_bytes('{8'h5f, 8'h41, 8'haa, BREAK_BYTE});
        push_bytes('{8'hf0});
        push_bytes('{8'h82});
        // random buffers: mostly well formed, some broken, some noise
        total = beats_q.size();
        while (total < 700) begin
            case ($urandom_range(0, 9))
                0: repeat ($urandom_range(1, 6)) enc_q.push_back(8'($urandom));
                1, 2: begin
                    put_value(0);
                    pos = $urandom_range(0, enc_q.size() - 1);
                    case ($urandom_range(0, 2))
                        0: while (enc_q.size() > pos + 1) void'(enc_q.pop_back());
                        1: enc_q[pos] = 8'($urandom);
                        default: enc_q.insert(pos, 8'($urandom));
                    endcase
                end
                default: repeat ($urandom_range(1, 3)) put_value(0);
            endcase
            total += enc_q.size();
            flush_buffer($urandom_range(0, 19) == 0 || n_buffers == 40);
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // wait for the last beat to go out and every token to come back
        while (beats_q.size() != 0 || s_valid) @(posedge aclk);
        while (tokens_due.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        $display("tb: %0d bytes in %0d buffers, %0d tokens checked, %0d error tokens",
                 n_sent, n_buffers, n_tokens, n_err_tokens);
        $display("tb: receiver hold-off of %0d cycles and drain pauses exercised",
                 HOLD_CYCLES);
        if (n_mismatch == 0 && tokens_due.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    // input driver: hold each beat until accepted, gap between beats
    always @(posedge aclk) begin
        logic nv;
        in_t nd;
        int g;
        nv = s_valid;
        nd = s_data;
        g = gap_left;
        if (!aresetn) begin
            nv = 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                tokenize_byte(s_data);
                n_sent++;
                nv = 1'b0;
                g = ((n_sent / 64) % 3 == 1) ? 0 : $urandom_range(0, 15);
            end
            if (!nv) begin
                if (g > 0) begin
                    g--;
                end else if (beats_q.size() != 0
                        && !(beats_q[0].drain_first && tokens_due.size() != 0)) begin
                    nd = beats_q[0].beat;
                    void'(beats_q.pop_front());
                    nv = 1'b1;
                end
            end
        end
        s_valid <= nv;
        s_data <= nd;
        gap_left <= g;
    end

    // long receiver hold-off, once
    always @(posedge aclk) begin
        if (!hold_done && n_sent >= HOLD_AT_BEAT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // output monitor: check each token beat against the oldest prediction
    always @(posedge aclk) begin
        int st;
        out_t e;
        st = stall_left;
        if (aresetn && m_valid && m_ready) begin
            n_tokens++;
            if (m_data.token_kind == TK_ERROR) n_err_tokens++;
            if (tokens_due.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("tb: unexpected token kind=%0d arg=%h", m_data.token_kind,
                             m_data.argument);
            end else begin
                e = tokens_due.pop_front();
                if (m_data.token_kind !== e.token_kind || m_data.argument !== e.argument
                        || m_data.is_indefinite !== e.is_indefinite
                        || m_data.nest_level !== e.nest_level
                        || m_data.levels_closed !== e.levels_closed
                        || m_data.value_done !== e.value_done
                        || m_data.error_code !== e.error_code) begin
                    n_mismatch++;
                    if (n_mismatch <= 10) begin
                        $display("tb: token %0d exp k=%0d a=%h i=%0d l=%0d c=%0d d=%0d e=%0d",
                                 n_tokens, e.token_kind, e.argument, e.is_indefinite,
                                 e.nest_level, e.levels_closed, e.value_done, e.error_code);
                        $display("tb:   got k=%0d a=%h i=%0d l=%0d c=%0d d=%0d e=%0d",
                                 m_data.token_kind, m_data.argument, m_data.is_indefinite,
                                 m_data.nest_level, m_data.levels_closed, m_data.value_done,
                                 m_data.error_code);
                    end
                end
            end
            st = ((n_tokens / 50) % 3 == 2) ? 0 : $urandom_range(0, 15);
        end else if (st > 0) begin
            st--;
        end
        stall_left <= st;
        m_ready <= aresetn && st == 0 && hold_left == 0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

endmodule
